// ----- sv/lrcs_pkg.sv -----
package lrcs_pkg;
  localparam int LABELS = 256;
  localparam int LBL_W = 8;
  localparam int MAX_WIDTH = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int CNT_W = 21;
  localparam int SUM_W = 30;
  localparam int COL_W = 10;
  localparam int ROW_W = 11;
  localparam int DIM_W = 11;
  localparam int CEN_W = 14;
  localparam int DIV_W = SUM_W + 4;
  localparam int ENT_W = CNT_W + 2 * SUM_W;
  localparam logic [1:0] MODE_PIXEL = 2'd0;
  localparam logic [1:0] MODE_QUERY = 2'd1;
  localparam logic [1:0] MODE_FRAME = 2'd2;
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam logic [0:0] REG_WIDTH = 1'd0;
  localparam logic [0:0] REG_HEIGHT = 1'd1;

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic [SUM_W-1:0] xsum;
    logic [SUM_W-1:0] ysum;
  } entry_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [LBL_W-1:0] label;
  } in_t;

  typedef struct packed {
    logic [LBL_W-1:0] queried_label;
    logic present;
    logic is_background;
    logic [CNT_W-1:0] pixel_count;
    logic [CEN_W-1:0] centroid_x;
    logic [CEN_W-1:0] centroid_y;
  } out_t;

  typedef struct packed {
    logic start;
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] cnt;
  } div_req_t;
endpackage

// ----- sv/lrcs_if.sv -----
interface lrcs_in_if (input logic clk);
  logic valid;
  logic ready;
  lrcs_pkg::in_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface lrcs_out_if (input logic clk);
  logic valid;
  logic ready;
  lrcs_pkg::out_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- sv/lrcs_ram.sv -----
module lrcs_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 81
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ----- sv/lrcs_div.sv -----
// Restoring divider: quotient of (sum * 16) / count, one bit a cycle, saturated.
module lrcs_div (
  input  logic                      clk,
  input  logic                      rst,
  input  lrcs_pkg::div_req_t        req,
  output logic                      done,
  output logic [lrcs_pkg::CEN_W-1:0] quo
);
  localparam int CW = lrcs_pkg::CNT_W;
  localparam int DW = lrcs_pkg::DIV_W;

  logic [DW-1:0] dividend;
  logic [DW-1:0] q;
  logic [CW:0] rem;
  logic [CW-1:0] dvs;
  logic [5:0] steps;
  logic busy;
  logic [CW:0] trial;
  logic [CW+1:0] diff;

  always_comb begin
    trial = {rem[CW-1:0], dividend[DW-1]};
    diff = {1'b0, trial} - {2'b00, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        dividend <= {req.sum, 4'b0000};
        dvs <= req.cnt;
        rem <= '0;
        q <= '0;
        steps <= 6'(DW);
      end else if (busy) begin
        dividend <= {dividend[DW-2:0], 1'b0};
        if (!diff[CW+1]) begin
          rem <= diff[CW:0];
          q <= {q[DW-2:0], 1'b1};
        end else begin
          rem <= trial;
          q <= {q[DW-2:0], 1'b0};
        end
        steps <= steps - 6'd1;
        if (steps == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (dvs == '0) quo = '0;
    else if (q > DW'(16383)) quo = '1;
    else quo = q[lrcs_pkg::CEN_W-1:0];
  end
endmodule

// ----- sv/label_region_centroid_stats_core.sv -----
// Region centroid statistics over a raster-order stream of 8-bit labels.
// Input channel (in): mode and label. Mode pixel adds the pixel to its label's
// count and column/row sums; mode query returns one beat on the output channel;
// mode frame clears the statistics; the unused mode is dropped.
// Statistics live in one 256-entry RAM of count and both sums with a registered
// read. A pixel takes three steps: read, modify/write, then S_PWR, after which
// the next read may already see the new entry. No new item is taken until a
// pixel has passed all three, set by the read-modify-write round trip of the RAM port.
// A query reads the entry and runs two serial 34-step divisions sharing one
// divider; the result beat is valid once the read and both divisions are done,
// and is then held in an output register until the receiver takes it; no new
// item is taken while it waits.
// A frame item sweeps all 256 RAM entries, one entry a cycle.
// After reset the same clearing sweep runs before any item is taken;
// width resets to 640 and height to 480, writable over APB at 0x0 and 0x4.
// Width or height of zero counts as one, above 1024 as 1024.
module label_region_centroid_stats_core (
  input  logic                clk,
  input  logic                rst,
  lrcs_in_if.sink             in_ch,
  lrcs_out_if.source          out_ch,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLEAR = 3'd1;
  localparam logic [2:0] S_PRD   = 3'd2;
  localparam logic [2:0] S_PWR   = 3'd3;
  localparam logic [2:0] S_QRD   = 3'd4;
  localparam logic [2:0] S_DX    = 3'd5;
  localparam logic [2:0] S_DY    = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;
  localparam int LW = lrcs_pkg::LBL_W;

  logic [2:0] state;
  logic [lrcs_pkg::DIM_W-1:0] width_reg, height_reg;
  logic [lrcs_pkg::COL_W-1:0] col;
  logic [lrcs_pkg::ROW_W-1:0] row;
  logic [LW-1:0] bg_label, lbl, clr_addr;
  logic [lrcs_pkg::CNT_W-1:0] bg_count;
  logic [lrcs_pkg::COL_W-1:0] px_col;
  logic [lrcs_pkg::ROW_W-1:0] px_row;
  logic px_ok;
  lrcs_pkg::entry_t rd, wr, ent;
  logic we;
  logic [LW-1:0] waddr;
  lrcs_pkg::div_req_t dreq;
  logic ddone;
  logic [lrcs_pkg::CEN_W-1:0] dquo;
  lrcs_pkg::out_t obuf;
  logic [lrcs_pkg::DIM_W:0] w_eff, h_eff;
  // Row sum of the queried entry, kept for the second division.
  logic [lrcs_pkg::SUM_W-1:0] qysum;

  assign pready = 1'b1;
  always_comb begin
    case (paddr[2])
      lrcs_pkg::REG_WIDTH: prdata = 32'(width_reg);
      default: prdata = 32'(height_reg);
    endcase
  end

  always_comb begin
    if (width_reg == '0) w_eff = 12'd1;
    else if (width_reg > 11'(lrcs_pkg::MAX_WIDTH)) w_eff = 12'(lrcs_pkg::MAX_WIDTH);
    else w_eff = {1'b0, width_reg};
    if (height_reg == '0) h_eff = 12'd1;
    else if (height_reg > 11'(lrcs_pkg::MAX_HEIGHT)) h_eff = 12'(lrcs_pkg::MAX_HEIGHT);
    else h_eff = {1'b0, height_reg};
  end

  lrcs_ram #(.DEPTH(lrcs_pkg::LABELS), .WIDTH(lrcs_pkg::ENT_W)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wr),
    .raddr(in_ch.payload.label), .rdata(rd)
  );

  lrcs_div u_div (.clk(clk), .rst(rst), .req(dreq), .done(ddone), .quo(dquo));

  assign in_ch.ready = (state == S_IDLE);
  assign out_ch.valid = (state == S_OUT);
  assign out_ch.payload = obuf;

  always_comb begin
    ent = rd;
    ent.cnt = rd.cnt + 21'd1;
    ent.xsum = rd.xsum + 30'(px_col);
    ent.ysum = rd.ysum + 30'(px_row);
    we = 1'b0;
    waddr = lbl;
    wr = ent;
    if (state == S_CLEAR) begin
      we = 1'b1;
      waddr = clr_addr;
      wr = '0;
    end else if (state == S_PRD && px_ok) begin
      we = 1'b1;
    end
    dreq.start = 1'b0;
    dreq.sum = rd.xsum;
    dreq.cnt = rd.cnt;
    if (state == S_QRD) dreq.start = 1'b1;
    if (state == S_DX && ddone) begin
      dreq.start = 1'b1;
      dreq.sum = qysum;
      dreq.cnt = obuf.pixel_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      width_reg <= 11'd640;
      height_reg <= 11'd480;
      col <= '0;
      row <= '0;
      bg_label <= '0;
      bg_count <= '0;
    end else begin
      if (psel && penable && pwrite) begin
        case (paddr[2])
          lrcs_pkg::REG_WIDTH: width_reg <= pwdata[10:0];
          default: height_reg <= pwdata[10:0];
        endcase
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 8'd1;
          if (clr_addr == 8'(lrcs_pkg::LABELS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_ch.valid) begin
            lbl <= in_ch.payload.label;
            case (in_ch.payload.mode)
              lrcs_pkg::MODE_PIXEL: begin
                state <= S_PRD;
                px_ok <= 1'b0;
                if ({1'b0, row} < h_eff) begin
                  if ({2'b00, col} >= w_eff) begin
                    if ({1'b0, row} + 12'd1 < h_eff) begin
                      px_ok <= 1'b1;
                      px_col <= '0;
                      px_row <= row + 11'd1;
                      if (w_eff == 12'd1) begin
                        col <= '0;
                        row <= row + 11'd2;
                      end else begin
                        col <= 10'd1;
                        row <= row + 11'd1;
                      end
                    end else begin
                      col <= '0;
                      row <= row + 11'd1;
                    end
                  end else begin
                    px_ok <= 1'b1;
                    px_col <= col;
                    px_row <= row;
                    if ({2'b00, col} + 12'd1 >= w_eff) begin
                      col <= '0;
                      row <= row + 11'd1;
                    end else begin
                      col <= col + 10'd1;
                    end
                  end
                end
              end
              lrcs_pkg::MODE_QUERY: state <= S_QRD;
              lrcs_pkg::MODE_FRAME: begin
                state <= S_CLEAR;
                clr_addr <= '0;
                col <= '0;
                row <= '0;
                bg_label <= '0;
                bg_count <= '0;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_PRD: begin
          state <= S_PWR;
          if (px_ok && (ent.cnt > bg_count ||
              (ent.cnt == bg_count && lbl < bg_label))) begin
            bg_count <= ent.cnt;
            bg_label <= lbl;
          end
        end
        S_PWR: state <= S_IDLE;
        S_QRD: begin
          qysum <= rd.ysum;
          obuf.queried_label <= lbl;
          obuf.pixel_count <= rd.cnt;
          obuf.is_background <= (lbl == bg_label);
          obuf.present <= (rd.cnt != '0) && (lbl != bg_label);
          state <= S_DX;
        end
        S_DX: if (ddone) begin
          obuf.centroid_x <= dquo;
          state <= S_DY;
        end
        S_DY: if (ddone) begin
          obuf.centroid_y <= dquo;
          state <= S_OUT;
        end
        S_OUT: if (out_ch.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
